/* hdl/gcml_pkg.sv */
// ----------------------------------------------------------------------------
// gcml_pkg
// Shared constants, result codes, controller states and the command and
// status bundles between the controller and the datapath of the group cache
// directory.
// ----------------------------------------------------------------------------
package gcml_pkg;

    // directory geometry
    localparam int CACHE_ENTRIES = 8;
    localparam int GROUP_BITS    = 16;
    localparam int POS_W         = $clog2(CACHE_ENTRIES);
    localparam int COUNT_W       = $clog2(CACHE_ENTRIES + 1);
    localparam int SLOT_W        = 3;
    localparam int STATUS_W      = 2;

    // result beat layout
    localparam int RES_BITS = STATUS_W + SLOT_W + 1 + GROUP_BITS;
    localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;
    localparam int IN_W     = ((GROUP_BITS + 7) / 8) * 8;

    // result status codes
    localparam logic [STATUS_W-1:0] RES_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] RES_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] RES_INCONS = 2'd3;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the request group from the input beat
        logic commit;    // update the directory and load the result register
    } dp_cmd_t;

    // datapath to controller and checks
    typedef struct packed {
        logic [COUNT_W-1:0] loaded_count;
    } dp_stat_t;

endpackage

/* hdl/gcml_ctrl.sv */
// ----------------------------------------------------------------------------
// gcml_ctrl
// Request sequencer: takes one input beat, runs the lookup state and hands
// the result to the output register as soon as it is free.
// ----------------------------------------------------------------------------
module gcml_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gcml_pkg::dp_cmd_t cmd
);
    import gcml_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOOKUP: begin
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result beat valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hdl/gcml_dpath.sv */
// ----------------------------------------------------------------------------
// gcml_dpath
// Directory registers, group count register, tag compare across all
// positions, move-to-front shift and the result register.
// ----------------------------------------------------------------------------
module gcml_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gcml_pkg::GROUP_BITS-1:0]       cfg_wr_data,
    input  logic [gcml_pkg::GROUP_BITS-1:0]       s_group,
    input  gcml_pkg::dp_cmd_t                     cmd,
    output gcml_pkg::dp_stat_t                    stat,
    output logic [gcml_pkg::RES_BITS-1:0]         result
);
    import gcml_pkg::*;

    // directory state
    logic [GROUP_BITS-1:0] grp_reg   [CACHE_ENTRIES];
    logic [GROUP_BITS-1:0] grp_next  [CACHE_ENTRIES];
    logic                  vld_reg   [CACHE_ENTRIES];
    logic                  vld_next  [CACHE_ENTRIES];
    logic [SLOT_W-1:0]     slot_reg  [CACHE_ENTRIES];
    logic [SLOT_W-1:0]     slot_next [CACHE_ENTRIES];
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [GROUP_BITS-1:0] gcount_reg;
    logic [GROUP_BITS-1:0] req_reg;

    // result register
    logic [RES_BITS-1:0]   res_reg, res_next;

    // lookup signals
    logic                  out_of_range;
    logic                  front_hit;
    logic                  direct_mode;
    logic [CACHE_ENTRIES-1:0] match;
    logic                  found;
    logic [POS_W-1:0]      hit_pos;
    logic [COUNT_W-1:0]    cnt_inc;
    logic [POS_W-1:0]      victim;
    logic [POS_W-1:0]      sel_pos;
    logic [GROUP_BITS-1:0] sel_grp;
    logic                  sel_vld;
    logic [SLOT_W-1:0]     sel_slot;
    logic [STATUS_W-1:0]   r_status;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_ev;
    logic [GROUP_BITS-1:0] r_evg;

    assign out_of_range = req_reg >= gcount_reg;
    assign front_hit    = vld_reg[0] && (grp_reg[0] == req_reg);
    assign direct_mode  = gcount_reg <= GROUP_BITS'(CACHE_ENTRIES);

    // tag compare over the loaded positions
    always_comb begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            match[i] = vld_reg[i] && (grp_reg[i] == req_reg)
                       && (COUNT_W'(i) < cnt_reg);
        end
    end

    // lowest matching position
    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                found   = 1'b1;
                hit_pos = POS_W'(i);
            end
        end
    end

    // victim position on a miss
    assign cnt_inc = (cnt_reg < COUNT_W'(CACHE_ENTRIES)) ? cnt_reg + 1'b1 : cnt_reg;
    assign victim  = POS_W'(cnt_inc - 1'b1);

    // single position read
    assign sel_pos  = direct_mode ? req_reg[POS_W-1:0] : (found ? hit_pos : victim);
    assign sel_grp  = grp_reg[sel_pos];
    assign sel_vld  = vld_reg[sel_pos];
    assign sel_slot = slot_reg[sel_pos];

    // directory update and result
    always_comb begin
        for (int j = 0; j < CACHE_ENTRIES; j++) begin
            grp_next[j]  = grp_reg[j];
            vld_next[j]  = vld_reg[j];
            slot_next[j] = slot_reg[j];
        end
        cnt_next = cnt_reg;
        r_status = RES_HIT;
        r_slot   = '0;
        r_ev     = 1'b0;
        r_evg    = '0;

        if (out_of_range) begin
            r_status = RES_RANGE;
        end else if (front_hit) begin
            r_status = RES_HIT;
            r_slot   = slot_reg[0];
        end else if (direct_mode) begin
            r_slot = sel_slot;
            if (sel_vld) begin
                r_status = (sel_grp == req_reg) ? RES_HIT : RES_INCONS;
            end else begin
                r_status          = RES_MISS;
                grp_next[sel_pos] = req_reg;
                vld_next[sel_pos] = 1'b1;
            end
        end else begin
            // move the selected position to the front
            for (int j = 1; j < CACHE_ENTRIES; j++) begin
                if (POS_W'(j) <= sel_pos) begin
                    grp_next[j]  = grp_reg[j-1];
                    vld_next[j]  = vld_reg[j-1];
                    slot_next[j] = slot_reg[j-1];
                end
            end
            grp_next[0]  = req_reg;
            vld_next[0]  = 1'b1;
            slot_next[0] = sel_slot;
            r_slot       = sel_slot;
            if (found) begin
                r_status = RES_HIT;
            end else begin
                r_status = RES_MISS;
                cnt_next = cnt_inc;
                r_ev     = sel_vld;
                r_evg    = sel_vld ? sel_grp : '0;
            end
        end
        res_next = {r_evg, r_ev, r_slot, r_status};
    end

    // control state: directory tags, valid bits, slots, count, group count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                grp_reg[i]  <= '0;
                vld_reg[i]  <= 1'b0;
                slot_reg[i] <= SLOT_W'(i);
            end
            cnt_reg    <= '0;
            gcount_reg <= GROUP_BITS'(1);
        end else begin
            if (cmd.commit) begin
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    grp_reg[i]  <= grp_next[i];
                    vld_reg[i]  <= vld_next[i];
                    slot_reg[i] <= slot_next[i];
                end
                cnt_reg <= cnt_next;
            end
            if (cfg_wr_en) begin
                gcount_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_group;
        end
        if (cmd.commit) begin
            res_reg <= res_next;
        end
    end

    assign result            = res_reg;
    assign stat.loaded_count = cnt_reg;

endmodule

/* hdl/group_cache_move_to_front_lru_unit.sv */
// ----------------------------------------------------------------------------
// group_cache_move_to_front_lru_unit
// Move-to-front directory of cached group numbers with direct and LRU modes.
// ----------------------------------------------------------------------------
// A request beat is accepted into the request register, and the lookup state
// that follows compares the group against all eight directory positions in
// parallel, in LRU mode shifts the directory to move the chosen entry to the
// front, and loads the result register. A request is held in the lookup
// state for as long as the previous result is still waiting on the result
// channel. The user must write the group count register only while no
// request is in progress; the block does not enforce it. It resets to one.
module group_cache_move_to_front_lru_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gcml_pkg::GROUP_BITS-1:0] cfg_wr_data,   // group_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gcml_pkg::IN_W-1:0]       s_tdata,       // group
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gcml_pkg::OUT_W-1:0]      m_tdata        // status, slot, evicted, evicted_group
);
    import gcml_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [RES_BITS-1:0] result;

    gcml_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gcml_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_group     (s_tdata[GROUP_BITS-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result)
    );

    // result beat, zero padded to whole bytes
    assign m_tdata = OUT_W'(result);

    // checks
    a_one_beat_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat accepted during lookup");

    a_no_capture_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.loaded_count <= COUNT_W'(CACHE_ENTRIES))
        else $error("loaded count beyond directory size");

endmodule

/* test/group_cache_move_to_front_lru_unit_test.sv */
// ----------------------------------------------------------------------------
// group_cache_move_to_front_lru_unit_test
// Self-checking bench for the move-to-front group cache directory. A local
// copy of the directory predicts each result beat: range checks, direct
// mode with its inconsistent tags, and LRU mode with promotion, fill and
// eviction. Directed requests come first, then random phases over several
// group counts, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module group_cache_move_to_front_lru_unit_test;
    import gcml_pkg::*;

    localparam int RUN_LIMIT  = 100000;
    localparam int HOLD_BEATS = 150;

    // one result beat, last field in the lowest bits
    typedef struct packed {
        logic [GROUP_BITS-1:0] evicted_group;
        logic                  evicted;
        logic [SLOT_W-1:0]     slot;
        logic [STATUS_W-1:0]   status;
    } dir_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [GROUP_BITS-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;    // group
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;    // status, slot, evicted, evicted_group

    // local copy of the directory
    logic [GROUP_BITS-1:0] tag_of [CACHE_ENTRIES];
    logic                  held [CACHE_ENTRIES];
    logic [SLOT_W-1:0]     slot_of [CACHE_ENTRIES];
    int                    lru_fill;
    logic [GROUP_BITS-1:0] dir_group_count;

    dir_result_t pending_results [$];
    int          fail_count;
    int          cycle_count;
    int          stall_cycles;
    bit          steady;

    group_cache_move_to_front_lru_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // shift positions 0..p-1 back by one and put position p at the front
    function automatic void promote_position(input int p);
        logic [GROUP_BITS-1:0] t;
        logic                  h;
        logic [SLOT_W-1:0]     s;
        int                    j;
        t = tag_of[p];
        h = held[p];
        s = slot_of[p];
        for (j = p; j > 0; j--) begin
            tag_of[j]  = tag_of[j-1];
            held[j]    = held[j-1];
            slot_of[j] = slot_of[j-1];
        end
        tag_of[0]  = t;
        held[0]    = h;
        slot_of[0] = s;
    endfunction

    // answer one request and update the local directory
    function automatic dir_result_t lookup_directory(input logic [GROUP_BITS-1:0] g);
        dir_result_t r;
        int          hit_pos;
        int          lim;
        int          victim;
        int          i;
        r = '0;
        hit_pos = -1;
        if (g >= dir_group_count) begin
            r.status = RES_RANGE;
        end else if (held[0] && tag_of[0] == g) begin
            r.status = RES_HIT;
            r.slot   = slot_of[0];
        end else if (dir_group_count <= CACHE_ENTRIES) begin
            // direct mode: position equals group
            r.slot = slot_of[g];
            if (held[g]) begin
                r.status = (tag_of[g] == g) ? RES_HIT : RES_INCONS;
            end else begin
                tag_of[g] = g;
                held[g]   = 1'b1;
                r.status  = RES_MISS;
            end
        end else begin
            // lru mode: search the loaded positions only
            lim = lru_fill;
            for (i = 0; i < lim; i++) begin
                if (hit_pos < 0 && held[i] && tag_of[i] == g)
                    hit_pos = i;
            end
            if (hit_pos >= 0) begin
                promote_position(hit_pos);
                r.status = RES_HIT;
                r.slot   = slot_of[0];
            end else begin
                if (lim < CACHE_ENTRIES)
                    lim++;
                lru_fill = lim;
                victim = lim - 1;
                if (held[victim]) begin
                    r.evicted       = 1'b1;
                    r.evicted_group = tag_of[victim];
                end
                promote_position(victim);
                tag_of[0] = g;
                held[0]   = 1'b1;
                r.status  = RES_MISS;
                r.slot    = slot_of[0];
            end
        end
        return r;
    endfunction

    // receiver: random stalls, long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (stall_cycles > 0) begin
            m_tready = 1'b0;
            stall_cycles = stall_cycles - 1;
        end else begin
            m_tready = steady || ($urandom_range(0, 99) >= 31);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        dir_result_t got;
        dir_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_BITS-1:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    fail_count++;
                end
                if (got.evicted_group !== want.evicted_group) begin
                    $error("evicted_group: expected %0d, got %0d",
                           want.evicted_group, got.evicted_group);
                    fail_count++;
                end
            end
        end
    end

    // offer one request beat, called and left at a falling edge
    task automatic send_group(input logic [GROUP_BITS-1:0] g);
        while (!steady && $urandom_range(0, 99) < 31) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = g;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(lookup_directory(g));
        @(negedge aclk);
    endtask

    // stop offering and wait until every result is back
    task automatic settle_directory();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // one register write while idle
    task automatic write_group_count(input logic [GROUP_BITS-1:0] v);
        settle_directory();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        dir_group_count = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // default group count of one after reset
    task automatic test_reset_count();
        send_group(16'd0);
        send_group(16'd0);
        send_group(16'hFFFF);
    endtask

    // direct mode at its largest group count
    task automatic test_direct_mode();
        write_group_count(16'(CACHE_ENTRIES));
        send_group(16'd7);
        send_group(16'd3);
        send_group(16'd7);
        send_group(16'd8);
    endtask

    // smallest lru count: stale direct entries get evicted
    task automatic test_stale_eviction();
        write_group_count(16'(CACHE_ENTRIES + 1));
        send_group(16'd8);
        send_group(16'd3);
        send_group(16'd8);
    endtask

    // back to direct mode over a reordered directory
    task automatic test_inconsistent_tag();
        write_group_count(16'(CACHE_ENTRIES));
        send_group(16'd0);
        send_group(16'd1);
        send_group(16'd3);
    endtask

    // a count of zero rejects everything
    task automatic test_zero_count();
        write_group_count(16'd0);
        send_group(16'd0);
    endtask

    // full lru range: fill, overflow, deep hit
    task automatic test_lru_overflow();
        int k;
        write_group_count(16'hFFFF);
        send_group(16'hFFFE);
        for (k = 0; k < CACHE_ENTRIES; k++)
            send_group(16'(16'h5A00 + k));
        send_group(16'h5A01);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        int k;
        write_group_count(16'd40);
        @(posedge aclk);
        stall_cycles = HOLD_BEATS;
        @(negedge aclk);
        for (k = 0; k < 20; k++)
            send_group(16'($urandom_range(0, 44)));
    endtask

    // random phases over several group counts
    task automatic test_random_requests();
        logic [GROUP_BITS-1:0] counts [9];
        logic [GROUP_BITS-1:0] working [12];
        logic [GROUP_BITS-1:0] g;
        int                    ph;
        int                    k;
        int                    pick;
        counts = '{16'd1, 16'd2, 16'd8, 16'd9, 16'd16, 16'hFFFF,
                   16'($urandom_range(17, 65534)), 16'd0, 16'd5};
        for (ph = 0; ph < 9; ph++) begin
            write_group_count(counts[ph]);
            // working set a little larger than the directory
            for (k = 0; k < 12; k++)
                working[k] = 16'($urandom_range(0, 32'(counts[ph]) + 1));
            // one phase runs with no gaps on either side
            steady = (ph == 5);
            for (k = 0; k < 50; k++) begin
                pick = $urandom_range(0, 15);
                if (pick < 12)
                    g = working[pick];
                else
                    g = 16'($urandom());
                send_group(g);
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        fail_count   = 0;
        cycle_count  = 0;
        stall_cycles = 0;
        steady       = 1'b0;
        // directory state after reset
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            tag_of[i]  = '0;
            held[i]    = 1'b0;
            slot_of[i] = SLOT_W'(i);
        end
        lru_fill        = 0;
        dir_group_count = 16'd1;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_count();
        test_direct_mode();
        test_stale_eviction();
        test_inconsistent_tag();
        test_zero_count();
        test_lru_overflow();
        test_backpressure();
        test_random_requests();

        settle_directory();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* group_cache_move_to_front_lru_unit.f */
hdl/gcml_pkg.sv
hdl/gcml_ctrl.sv
hdl/gcml_dpath.sv
hdl/group_cache_move_to_front_lru_unit.sv
test/group_cache_move_to_front_lru_unit_test.sv
